>>> hw/rtl/brba_pkg.sv
// Package for the beam resource block budget allocator.
// Holds sizes, command and register codes, the record layout and the
// controller-to-datapath command and status types. Depends on nothing.
package brba_pkg;

   localparam int NumBeams = 16;
   localparam int SpsSlots = 64;
   localparam int NumRecs  = 2 * NumBeams;
   localparam int RecIdxW  = $clog2(NumRecs);
   localparam int SlotIdxW = (SpsSlots > 1) ? $clog2(SpsSlots) : 1;
   localparam int SlotCntW = $clog2(SpsSlots + 1);

   localparam int CmdW     = 3;
   localparam int BeamW    = 4;
   localparam int AmountW  = 10;
   localparam int MaskW    = 64;
   localparam int GrantW   = 10;
   localparam int UsedW    = 9;
   localparam int SharedW  = 12;
   localparam int AdmitW   = 10;
   localparam int BudgetW  = 9;
   localparam int RegionW  = 7;
   localparam int CapW     = 10;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 10;

   localparam logic [SharedW-1:0] SharedMax   = '1;
   localparam logic [BudgetW-1:0] BudgetReset = BudgetW'(25);

   localparam logic [CsrIdxW-1:0] CSR_DL_BUDGET    = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CSR_UL_BUDGET    = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] CSR_DL_SPS_REGION = CsrIdxW'(2);
   localparam logic [CsrIdxW-1:0] CSR_UL_SPS_REGION = CsrIdxW'(3);
   localparam logic [CsrIdxW-1:0] CSR_DL_ADMIT_CAP = CsrIdxW'(4);
   localparam logic [CsrIdxW-1:0] CSR_UL_ADMIT_CAP = CsrIdxW'(5);

   typedef enum logic [CmdW-1:0] {
      CMD_ALLOC     = 3'd0,
      CMD_SHARED    = 3'd1,
      CMD_ADMIT     = 3'd2,
      CMD_RELEASE   = 3'd3,
      CMD_CLAIM     = 3'd4,
      CMD_FREE      = 3'd5,
      CMD_RESET_DIR = 3'd6,
      CMD_RESET_ALL = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [UsedW-1:0]    used;
      logic [SharedW-1:0]  shared;
      logic [AdmitW-1:0]   admitted;
      logic [SpsSlots-1:0] busy;
   } rec_type;

   localparam int RecW = $bits(rec_type);

   typedef struct packed {
      logic latch_req;
      logic rd_en;
      logic load;
      logic scan_step;
      logic apply;
      logic write_back;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

>>> hw/rtl/brba_if.sv
// Request and response channel interfaces of the budget allocator.
// Depends on brba_pkg for the field widths.
interface brba_req_if
   import brba_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CmdW-1:0]     command;
   logic [BeamW-1:0]    beam;
   logic                uplink;
   logic [AmountW-1:0]  amount;
   logic [MaskW-1:0]    free_mask;

   modport source (output valid, command, beam, uplink, amount, free_mask, input ready);
   modport sink   (input valid, command, beam, uplink, amount, free_mask, output ready);
endinterface

interface brba_rsp_if
   import brba_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [GrantW-1:0]   granted;
   logic                accepted;
   logic [MaskW-1:0]    claimed_mask;
   logic [UsedW-1:0]    used_after;
   logic [SharedW-1:0]  shared_after;
   logic [AdmitW-1:0]   admitted_after;
   logic [BudgetW-1:0]  remaining_after;

   modport source (output valid, granted, accepted, claimed_mask, used_after, shared_after,
                   admitted_after, remaining_after, input ready);
   modport sink   (input valid, granted, accepted, claimed_mask, used_after, shared_after,
                   admitted_after, remaining_after, output ready);
endinterface

>>> hw/rtl/brba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module brba_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                           rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/brba_ctrl.sv
// Controller state machine of the budget allocator: request and response
// handshakes and the sequence of datapath commands. Depends on brba_pkg.
module brba_ctrl
   import brba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SCAN,
      ST_APPLY,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dp_cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.latch_req = 1'b1;
               state_in         = ST_READ;
            end
         end
         ST_READ: begin
            dp_cmd.rd_en = 1'b1;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            dp_cmd.load = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (dp_status.scan_done) begin
               state_in = ST_APPLY;
            end else begin
               dp_cmd.scan_step = 1'b1;
            end
         end
         ST_APPLY: begin
            dp_cmd.apply = 1'b1;
            state_in     = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.write_back = 1'b1;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

>>> hw/rtl/brba_dp.sv
// Datapath of the budget allocator: configuration registers, record RAM
// with valid bits, the slot scanner and the result register.
// Depends on brba_pkg and brba_ram.
module brba_dp
   import brba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CsrDataW-1:0]  csr_wr_data,
   input  logic [CmdW-1:0]      req_command,
   input  logic [BeamW-1:0]     req_beam,
   input  logic                 req_uplink,
   input  logic [AmountW-1:0]   req_amount,
   input  logic [MaskW-1:0]     req_free_mask,
   input  dp_cmd_type           dp_cmd,
   output dp_status_type        dp_status,
   output logic [GrantW-1:0]    rsp_granted,
   output logic                 rsp_accepted,
   output logic [MaskW-1:0]     rsp_claimed_mask,
   output logic [UsedW-1:0]     rsp_used_after,
   output logic [SharedW-1:0]   rsp_shared_after,
   output logic [AdmitW-1:0]    rsp_admitted_after,
   output logic [BudgetW-1:0]   rsp_remaining_after
);
   logic [BudgetW-1:0] dl_budget_ff, ul_budget_ff;
   logic [RegionW-1:0] dl_region_ff, ul_region_ff;
   logic [CapW-1:0]    dl_cap_ff, ul_cap_ff;

   logic [NumRecs-1:0] valid_ff, valid_in;

   cmd_type             cmd_ff, cmd_in;
   logic [RecIdxW-1:0]  rec_ff, rec_in;
   logic                in_range_ff, in_range_in;
   logic                up_ff, up_in;
   logic [AmountW-1:0]  amount_ff, amount_in;
   logic [SpsSlots-1:0] mask_ff, mask_in;

   logic [UsedW-1:0]    used_ff, used_in;
   logic [SharedW-1:0]  shared_ff, shared_in;
   logic [AdmitW-1:0]   admitted_ff, admitted_in;
   logic [SpsSlots-1:0] busy_ff, busy_in;
   logic [SpsSlots-1:0] pick_ff, pick_in;
   logic [SlotCntW-1:0] cnt_ff, cnt_in;
   logic [SlotCntW-1:0] slot_ff, slot_in;
   logic [GrantW-1:0]   granted_ff, granted_in;
   logic                accepted_ff, accepted_in;

   logic [GrantW-1:0]   res_granted_ff, res_granted_in;
   logic                res_accepted_ff, res_accepted_in;
   logic [MaskW-1:0]    res_mask_ff, res_mask_in;
   logic [UsedW-1:0]    res_used_ff, res_used_in;
   logic [SharedW-1:0]  res_shared_ff, res_shared_in;
   logic [AdmitW-1:0]   res_admitted_ff, res_admitted_in;
   logic [BudgetW-1:0]  res_remaining_ff, res_remaining_in;

   logic [RecW-1:0]     ram_rd_data;
   rec_type             rd_rec, load_rec, wr_rec;

   logic [BudgetW-1:0]  budget;
   logic [RegionW-1:0]  region_raw;
   logic [SlotCntW-1:0] region;
   logic [CapW-1:0]     cap;
   logic [BudgetW-1:0]  remaining;
   logic [SlotIdxW-1:0] slot_idx;
   logic                claim_more;
   logic [GrantW-1:0]   grant_sel;
   logic [SharedW:0]    shared_sum;
   logic [AdmitW:0]     admit_sum;
   logic [UsedW-1:0]    freed;

   brba_ram #(
      .Width (RecW),
      .Depth (NumRecs)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.write_back && in_range_ff),
      .wr_addr (rec_ff),
      .wr_data (wr_rec),
      .rd_en   (dp_cmd.rd_en),
      .rd_addr (rec_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_rec = rec_type'(ram_rd_data);

   always_comb begin
      wr_rec.used     = used_ff;
      wr_rec.shared   = shared_ff;
      wr_rec.admitted = admitted_ff;
      wr_rec.busy     = busy_ff;
   end

   always_comb begin
      budget     = up_ff ? ul_budget_ff : dl_budget_ff;
      region_raw = up_ff ? ul_region_ff : dl_region_ff;
      cap        = up_ff ? ul_cap_ff : dl_cap_ff;
      if (int'(region_raw) > SpsSlots) begin
         region = SlotCntW'(SpsSlots);
      end else begin
         region = SlotCntW'(region_raw);
      end
      remaining  = (used_ff < budget) ? (budget - used_ff) : '0;
      slot_idx   = slot_ff[SlotIdxW-1:0];
      claim_more = (slot_ff < region) && (AmountW'(cnt_ff) < amount_ff)
                   && (BudgetW'(cnt_ff) < remaining);
      freed      = UsedW'(cnt_ff);
   end

   always_comb begin
      if (cmd_ff == CMD_CLAIM) begin
         dp_status.scan_done = !claim_more;
      end else if (cmd_ff == CMD_FREE) begin
         dp_status.scan_done = (slot_ff == SlotCntW'(SpsSlots));
      end else begin
         dp_status.scan_done = 1'b1;
      end
   end

   always_comb begin
      if ((in_range_ff && valid_ff[rec_ff]) && (cmd_ff != CMD_RESET_ALL)) begin
         load_rec = rd_rec;
      end else begin
         load_rec = '0;
      end
   end

   always_comb begin
      cmd_in      = cmd_ff;
      rec_in      = rec_ff;
      in_range_in = in_range_ff;
      up_in       = up_ff;
      amount_in   = amount_ff;
      mask_in     = mask_ff;
      valid_in    = valid_ff;
      used_in     = used_ff;
      shared_in   = shared_ff;
      admitted_in = admitted_ff;
      busy_in     = busy_ff;
      pick_in     = pick_ff;
      cnt_in      = cnt_ff;
      slot_in     = slot_ff;
      granted_in  = granted_ff;
      accepted_in = accepted_ff;
      grant_sel   = '0;
      shared_sum  = '0;
      admit_sum   = '0;

      res_granted_in   = res_granted_ff;
      res_accepted_in  = res_accepted_ff;
      res_mask_in      = res_mask_ff;
      res_used_in      = res_used_ff;
      res_shared_in    = res_shared_ff;
      res_admitted_in  = res_admitted_ff;
      res_remaining_in = res_remaining_ff;

      if (dp_cmd.latch_req) begin
         cmd_in      = cmd_type'(req_command);
         rec_in      = RecIdxW'({req_beam, req_uplink});
         in_range_in = (int'(req_beam) < NumBeams);
         up_in       = req_uplink;
         amount_in   = req_amount;
         mask_in     = req_free_mask[SpsSlots-1:0];
      end

      if (dp_cmd.load) begin
         if (cmd_ff == CMD_RESET_ALL) begin
            valid_in = '0;
         end
         used_in     = load_rec.used;
         shared_in   = load_rec.shared;
         admitted_in = load_rec.admitted;
         busy_in     = load_rec.busy;
         pick_in     = '0;
         cnt_in      = '0;
         slot_in     = '0;
         granted_in  = '0;
         accepted_in = 1'b0;
      end

      if (dp_cmd.scan_step) begin
         slot_in = slot_ff + SlotCntW'(1);
         if (cmd_ff == CMD_CLAIM) begin
            if (!busy_ff[slot_idx]) begin
               pick_in[slot_idx] = 1'b1;
               cnt_in            = cnt_ff + SlotCntW'(1);
            end
         end else begin
            if (busy_ff[slot_idx] && mask_ff[slot_idx]) begin
               busy_in[slot_idx] = 1'b0;
               cnt_in            = cnt_ff + SlotCntW'(1);
            end
         end
      end

      if (dp_cmd.apply) begin
         unique case (cmd_ff)
            CMD_ALLOC: begin
               grant_sel  = (amount_ff < GrantW'(remaining)) ? amount_ff : GrantW'(remaining);
               granted_in = grant_sel;
               used_in    = used_ff + UsedW'(grant_sel);
            end
            CMD_SHARED: begin
               grant_sel  = (amount_ff < GrantW'(used_ff)) ? amount_ff : GrantW'(used_ff);
               granted_in = grant_sel;
               shared_sum = {1'b0, shared_ff} + (SharedW + 1)'(grant_sel);
               if (shared_sum > (SharedW + 1)'(SharedMax)) begin
                  shared_in = SharedMax;
               end else begin
                  shared_in = shared_sum[SharedW-1:0];
               end
            end
            CMD_ADMIT: begin
               admit_sum = {1'b0, admitted_ff} + (AdmitW + 1)'(amount_ff);
               if ((amount_ff != '0) && (cap != '0) && (admit_sum <= (AdmitW + 1)'(cap))) begin
                  admitted_in = admit_sum[AdmitW-1:0];
                  granted_in  = amount_ff;
                  accepted_in = 1'b1;
               end
            end
            CMD_RELEASE: begin
               grant_sel   = (GrantW'(admitted_ff) < amount_ff) ? GrantW'(admitted_ff)
                                                                : amount_ff;
               granted_in  = grant_sel;
               admitted_in = admitted_ff - AdmitW'(grant_sel);
            end
            CMD_CLAIM: begin
               if ((amount_ff != '0) && (AmountW'(cnt_ff) >= amount_ff)) begin
                  busy_in     = busy_ff | pick_ff;
                  used_in     = used_ff + UsedW'(cnt_ff);
                  granted_in  = GrantW'(cnt_ff);
                  accepted_in = 1'b1;
               end
            end
            CMD_FREE: begin
               used_in    = (used_ff > freed) ? (used_ff - freed) : '0;
               granted_in = GrantW'(cnt_ff);
            end
            CMD_RESET_DIR: begin
               used_in   = '0;
               shared_in = '0;
               busy_in   = '0;
            end
            CMD_RESET_ALL: begin
               granted_in = '0;
            end
         endcase
      end

      if (dp_cmd.write_back) begin
         if (in_range_ff) begin
            valid_in[rec_ff] = 1'b1;
            res_granted_in   = granted_ff;
            res_accepted_in  = accepted_ff;
            res_mask_in      = ((cmd_ff == CMD_CLAIM) && accepted_ff) ? MaskW'(pick_ff) : '0;
            res_used_in      = used_ff;
            res_shared_in    = shared_ff;
            res_admitted_in  = admitted_ff;
            res_remaining_in = remaining;
         end else begin
            res_granted_in   = '0;
            res_accepted_in  = 1'b0;
            res_mask_in      = '0;
            res_used_in      = '0;
            res_shared_in    = '0;
            res_admitted_in  = '0;
            res_remaining_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_budget_ff <= BudgetReset;
         ul_budget_ff <= BudgetReset;
         dl_region_ff <= '0;
         ul_region_ff <= '0;
         dl_cap_ff    <= '0;
         ul_cap_ff    <= '0;
         valid_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_DL_BUDGET:     dl_budget_ff <= csr_wr_data[BudgetW-1:0];
               CSR_UL_BUDGET:     ul_budget_ff <= csr_wr_data[BudgetW-1:0];
               CSR_DL_SPS_REGION: dl_region_ff <= csr_wr_data[RegionW-1:0];
               CSR_UL_SPS_REGION: ul_region_ff <= csr_wr_data[RegionW-1:0];
               CSR_DL_ADMIT_CAP:  dl_cap_ff    <= csr_wr_data[CapW-1:0];
               CSR_UL_ADMIT_CAP:  ul_cap_ff    <= csr_wr_data[CapW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      rec_ff           <= rec_in;
      in_range_ff      <= in_range_in;
      up_ff            <= up_in;
      amount_ff        <= amount_in;
      mask_ff          <= mask_in;
      used_ff          <= used_in;
      shared_ff        <= shared_in;
      admitted_ff      <= admitted_in;
      busy_ff          <= busy_in;
      pick_ff          <= pick_in;
      cnt_ff           <= cnt_in;
      slot_ff          <= slot_in;
      granted_ff       <= granted_in;
      accepted_ff      <= accepted_in;
      res_granted_ff   <= res_granted_in;
      res_accepted_ff  <= res_accepted_in;
      res_mask_ff      <= res_mask_in;
      res_used_ff      <= res_used_in;
      res_shared_ff    <= res_shared_in;
      res_admitted_ff  <= res_admitted_in;
      res_remaining_ff <= res_remaining_in;
   end

   assign rsp_granted         = res_granted_ff;
   assign rsp_accepted        = res_accepted_ff;
   assign rsp_claimed_mask    = res_mask_ff;
   assign rsp_used_after      = res_used_ff;
   assign rsp_shared_after    = res_shared_ff;
   assign rsp_admitted_after  = res_admitted_ff;
   assign rsp_remaining_after = res_remaining_ff;
endmodule

>>> hw/rtl/beam_rb_budget_allocator.sv
// Top level of the per-beam resource block budget allocator.
// Depends on brba_pkg, brba_if, brba_ram, brba_ctrl and brba_dp.
//
//   Channel   Direction  Handshake           Carries
//   req_ch    in         valid / ready       command, beam, uplink, amount, free_mask
//   rsp_ch    out        valid / ready       granted, accepted, claimed_mask, counts after
//   csr_*     in         csr_wr_en only      register index and write data
//
// After acceptance a request passes through the read, load, scan, apply and write
// states before ready returns. A claim scans slots up to the SPS region; a free scans
// every SPS slot (64). The slot scanner sets the length of the scan.
// Reset is synchronous and clears all records at once through per-record valid bits.
// A pending response stalls only the final write-back of the next request.
module beam_rb_budget_allocator
   import brba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wr_data,
   brba_req_if.sink            req_ch,
   brba_rsp_if.source          rsp_ch
);
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   brba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   brba_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_command         (req_ch.command),
      .req_beam            (req_ch.beam),
      .req_uplink          (req_ch.uplink),
      .req_amount          (req_ch.amount),
      .req_free_mask       (req_ch.free_mask),
      .dp_cmd              (dp_cmd),
      .dp_status           (dp_status),
      .rsp_granted         (rsp_ch.granted),
      .rsp_accepted        (rsp_ch.accepted),
      .rsp_claimed_mask    (rsp_ch.claimed_mask),
      .rsp_used_after      (rsp_ch.used_after),
      .rsp_shared_after    (rsp_ch.shared_after),
      .rsp_admitted_after  (rsp_ch.admitted_after),
      .rsp_remaining_after (rsp_ch.remaining_after)
   );

   // The result register is loaded only when it is empty or being drained.
   a_wb_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.write_back |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("write-back while a response is still held");

   // An accepted request starts the record read in the next cycle.
   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> dp_cmd.rd_en)
      else $error("record read did not follow request acceptance");

   // A response appears only after a write-back.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(dp_cmd.write_back))
      else $error("response valid without a write-back");

   // A successful admit or claim always grants a nonzero count.
   a_accept_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.accepted) |-> (rsp_ch.granted != '0))
      else $error("accepted response with zero grant");
endmodule

>>> bench/beam_rb_budget_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for beam_rb_budget_allocator: directed and random request streams
// under several register settings, checked by a ledger class that mirrors every account.
// Depends on brba_pkg, the brba_req_if and brba_rsp_if interfaces, and the allocator RTL.
module beam_rb_budget_allocator_test;
   import brba_pkg::*;

   typedef struct packed {
      cmd_type             command;
      logic [BeamW-1:0]    beam;
      logic                uplink;
      logic [AmountW-1:0]  amount;
      logic [MaskW-1:0]    free_mask;
   } alloc_req_type;

   typedef struct packed {
      logic [GrantW-1:0]   granted;
      logic                accepted;
      logic [MaskW-1:0]    claimed_mask;
      logic [UsedW-1:0]    used_after;
      logic [SharedW-1:0]  shared_after;
      logic [AdmitW-1:0]   admitted_after;
      logic [BudgetW-1:0]  remaining_after;
   } alloc_rsp_type;

   class budget_ledger_type;
      logic [BudgetW-1:0]  budget [2];
      logic [RegionW-1:0]  region [2];
      logic [CapW-1:0]     cap [2];
      logic [UsedW-1:0]    used [NumRecs];
      logic [SharedW-1:0]  shared [NumRecs];
      logic [AdmitW-1:0]   admitted [NumRecs];
      logic [SpsSlots-1:0] busy [NumRecs];
      alloc_rsp_type       due_responses [$];
      int                  errors;
      int                  responses;
      int                  claims_won;
      int                  admits_won;
      int                  slots_freed;
      int                  saturations;

      function new();
         budget[0] = BudgetReset;
         budget[1] = BudgetReset;
         region[0] = '0;
         region[1] = '0;
         cap[0] = '0;
         cap[1] = '0;
         errors = 0;
         responses = 0;
         claims_won = 0;
         admits_won = 0;
         slots_freed = 0;
         saturations = 0;
         clear_records();
      endfunction

      function void clear_records();
         foreach (used[i]) begin
            used[i] = '0;
            shared[i] = '0;
            admitted[i] = '0;
            busy[i] = '0;
         end
      endfunction

      function void set_register(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
         case (idx)
            CSR_DL_BUDGET:     budget[0] = val[BudgetW-1:0];
            CSR_UL_BUDGET:     budget[1] = val[BudgetW-1:0];
            CSR_DL_SPS_REGION: region[0] = val[RegionW-1:0];
            CSR_UL_SPS_REGION: region[1] = val[RegionW-1:0];
            CSR_DL_ADMIT_CAP:  cap[0] = val[CapW-1:0];
            CSR_UL_ADMIT_CAP:  cap[1] = val[CapW-1:0];
            default: ;
         endcase
      endfunction

      function void post_request(alloc_req_type rq);
         alloc_rsp_type       ex;
         int                  u, rec, bud, lim, cnt, amt, room, n, s, sh;
         logic [SpsSlots-1:0] pick, hit;
         ex = '0;
         if (rq.command == CMD_RESET_ALL) begin
            clear_records();
         end
         if (int'(rq.beam) < NumBeams) begin
            u = int'(rq.uplink);
            rec = 2 * int'(rq.beam) + u;
            bud = int'(budget[u]);
            lim = (int'(region[u]) > SpsSlots) ? SpsSlots : int'(region[u]);
            amt = int'(rq.amount);
            cnt = int'(used[rec]);
            room = (cnt < bud) ? bud - cnt : 0;
            case (rq.command)
               CMD_ALLOC: begin
                  n = (amt < room) ? amt : room;
                  ex.granted = GrantW'(n);
                  used[rec] = UsedW'(cnt + n);
               end
               CMD_SHARED: begin
                  n = (amt < cnt) ? amt : cnt;
                  ex.granted = GrantW'(n);
                  sh = int'(shared[rec]) + n;
                  if (sh > int'(SharedMax)) begin
                     sh = int'(SharedMax);
                     saturations++;
                  end
                  shared[rec] = SharedW'(sh);
               end
               CMD_ADMIT: begin
                  if (amt != 0 && cap[u] != '0 && int'(admitted[rec]) + amt <= int'(cap[u])) begin
                     admitted[rec] = AdmitW'(int'(admitted[rec]) + amt);
                     ex.granted = GrantW'(amt);
                     ex.accepted = 1'b1;
                     admits_won++;
                  end
               end
               CMD_RELEASE: begin
                  n = (int'(admitted[rec]) < amt) ? int'(admitted[rec]) : amt;
                  admitted[rec] = AdmitW'(int'(admitted[rec]) - n);
                  ex.granted = GrantW'(n);
               end
               CMD_CLAIM: begin
                  if (lim != 0 && amt != 0) begin
                     n = 0;
                     pick = '0;
                     for (s = 0; s < lim && n < amt && n < room; s++) begin
                        if (!busy[rec][s]) begin
                           pick[s] = 1'b1;
                           n++;
                        end
                     end
                     if (n >= amt) begin
                        busy[rec] = busy[rec] | pick;
                        used[rec] = UsedW'(cnt + n);
                        ex.granted = GrantW'(n);
                        ex.claimed_mask = MaskW'(pick);
                        ex.accepted = 1'b1;
                        claims_won++;
                     end
                  end
               end
               CMD_FREE: begin
                  hit = busy[rec] & rq.free_mask[SpsSlots-1:0];
                  n = $countones(hit);
                  busy[rec] = busy[rec] & ~hit;
                  used[rec] = (cnt > n) ? UsedW'(cnt - n) : '0;
                  ex.granted = GrantW'(n);
                  slots_freed += n;
               end
               CMD_RESET_DIR: begin
                  used[rec] = '0;
                  shared[rec] = '0;
                  busy[rec] = '0;
               end
               default: ;
            endcase
            cnt = int'(used[rec]);
            room = (cnt < bud) ? bud - cnt : 0;
            ex.used_after = used[rec];
            ex.shared_after = shared[rec];
            ex.admitted_after = admitted[rec];
            ex.remaining_after = BudgetW'(room);
         end
         due_responses.insert(due_responses.size(), ex);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] seen);
         if (want !== seen) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
         end
      endfunction

      function void match_response(alloc_rsp_type got);
         alloc_rsp_type ex;
         responses++;
         if (due_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual granted 0x%0h",
                     $time, got.granted);
            return;
         end
         ex = due_responses.pop_front();
         check_field("granted", 64'(ex.granted), 64'(got.granted));
         check_field("accepted", 64'(ex.accepted), 64'(got.accepted));
         check_field("claimed_mask", 64'(ex.claimed_mask), 64'(got.claimed_mask));
         check_field("used_after", 64'(ex.used_after), 64'(got.used_after));
         check_field("shared_after", 64'(ex.shared_after), 64'(got.shared_after));
         check_field("admitted_after", 64'(ex.admitted_after), 64'(got.admitted_after));
         check_field("remaining_after", 64'(ex.remaining_after), 64'(got.remaining_after));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wr_data;

   brba_req_if req_ch ();
   brba_rsp_if rsp_ch ();

   budget_ledger_type ledger;
   int                burst_left;
   int                sent;
   int                settings_loaded;
   bit                hold_request = 1'b0;

   beam_rb_budget_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #20000000;
      $display("beam_rb_budget_allocator_test: done, errors");
      $finish;
   end

   // The receiver either follows a random stall pattern or, on request, holds off
   // for a long stretch so that the block backs up into its request channel.
   initial begin : rsp_pacing
      int mode, mode_left, hold_left;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_ch.ready = 1'b1;
               1: rsp_ch.ready = 1'($urandom_range(0, 1));
               2: rsp_ch.ready = ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready = ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_capture
      alloc_rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.granted = rsp_ch.granted;
         got.accepted = rsp_ch.accepted;
         got.claimed_mask = rsp_ch.claimed_mask;
         got.used_after = rsp_ch.used_after;
         got.shared_after = rsp_ch.shared_after;
         got.admitted_after = rsp_ch.admitted_after;
         got.remaining_after = rsp_ch.remaining_after;
         ledger.match_response(got);
      end
   end

   task automatic ask(input cmd_type cmd, input int beam, input bit up, input int amount,
                      input logic [MaskW-1:0] mask);
      alloc_req_type rq;
      rq.command = cmd;
      rq.beam = BeamW'(beam);
      rq.uplink = up;
      rq.amount = AmountW'(amount);
      rq.free_mask = mask;
      if (burst_left == 0) begin
         req_ch.valid = 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
      end
      burst_left--;
      req_ch.valid = 1'b1;
      req_ch.command = rq.command;
      req_ch.beam = rq.beam;
      req_ch.uplink = rq.uplink;
      req_ch.amount = rq.amount;
      req_ch.free_mask = rq.free_mask;
      do @(posedge clock); while (!req_ch.ready);
      ledger.post_request(rq);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid = 1'b0;
      while (ledger.due_responses.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input int val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = CsrDataW'(val);
      @(posedge clock);
      ledger.set_register(idx, CsrDataW'(val));
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic load_settings(input int dl_bud, input int ul_bud, input int dl_reg,
                                input int ul_reg, input int dl_cap, input int ul_cap);
      drain();
      csr_write(CSR_DL_BUDGET, dl_bud);
      csr_write(CSR_UL_BUDGET, ul_bud);
      csr_write(CSR_DL_SPS_REGION, dl_reg);
      csr_write(CSR_UL_SPS_REGION, ul_reg);
      csr_write(CSR_DL_ADMIT_CAP, dl_cap);
      csr_write(CSR_UL_ADMIT_CAP, ul_cap);
      settings_loaded++;
   endtask

   function automatic int pick_beam();
      return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
   endfunction

   function automatic int pick_amount();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 4);
         1: return $urandom_range(0, 64);
         2: return $urandom_range(0, 300);
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   function automatic logic [MaskW-1:0] pick_mask(input logic [SpsSlots-1:0] held);
      logic [MaskW-1:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: return '1;
         1: return r;
         2: return MaskW'(held) & r;
         3: return MaskW'(1) << $urandom_range(0, MaskW - 1);
         default: return MaskW'(held);
      endcase
   endfunction

   function automatic int pick_region();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
   endfunction

   // Mostly short well-formed sequences on one account, with random single requests
   // mixed in as noise.
   task automatic run_random(input int count);
      int stop, k, rec, b, amt;
      bit u;
      stop = sent + count;
      while (sent < stop) begin
         b = pick_beam();
         u = 1'($urandom_range(0, 1));
         rec = 2 * b + int'(u);
         k = $urandom_range(0, 99);
         if (k < 35) begin
            ask(cmd_type'($urandom_range(0, 6)), $urandom_range(0, 15), u, pick_amount(),
                pick_mask(ledger.busy[rec]));
         end else if (k < 60) begin
            repeat ($urandom_range(2, 8)) begin
               case ($urandom_range(0, 3))
                  0, 1: begin
                     amt = ($urandom_range(0, 3) == 0) ? pick_amount() : $urandom_range(1, 8);
                     ask(CMD_CLAIM, b, u, amt, '0);
                  end
                  2: ask(CMD_FREE, b, u, 0, pick_mask(ledger.busy[rec]));
                  default: ask(CMD_ALLOC, b, u, $urandom_range(0, 20), '0);
               endcase
            end
         end else if (k < 75) begin
            repeat ($urandom_range(2, 6)) begin
               if ($urandom_range(0, 2) != 0) begin
                  ask(CMD_ADMIT, b, u, $urandom_range(0, int'(ledger.cap[u]) / 3 + 2), '0);
               end else begin
                  ask(CMD_RELEASE, b, u, $urandom_range(0, 200), '0);
               end
            end
         end else if (k < 85) begin
            ask(CMD_ALLOC, b, u, 1023, '0);
            repeat ($urandom_range(3, 18)) begin
               ask(CMD_SHARED, b, u, ($urandom_range(0, 1) == 0) ? 1023 : pick_amount(), '0);
            end
         end else if (k < 99) begin
            ask(CMD_RESET_DIR, b, u, pick_amount(), pick_mask('1));
            ask(CMD_CLAIM, b, u, $urandom_range(1, 10), '0);
            ask(CMD_ALLOC, b, u, pick_amount(), '0);
         end else begin
            ask(CMD_RESET_ALL, $urandom_range(0, 15), u, pick_amount(), pick_mask('1));
         end
      end
   endtask

   initial begin
      ledger = new();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_ALLOC;
      req_ch.beam = '0;
      req_ch.uplink = 1'b0;
      req_ch.amount = '0;
      req_ch.free_mask = '0;
      burst_left = 0;
      sent = 0;
      settings_loaded = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register values as they come out of reset: SPS and admission are disabled.
      ask(CMD_ALLOC, 0, 1'b0, 0, '0);
      ask(CMD_ALLOC, 0, 1'b0, 1023, '0);
      ask(CMD_SHARED, 0, 1'b0, 1023, '0);
      ask(CMD_ADMIT, 0, 1'b0, 5, '0);
      ask(CMD_CLAIM, 0, 1'b0, 1, '0);
      ask(CMD_RELEASE, 0, 1'b0, 3, '0);
      ask(CMD_FREE, 15, 1'b1, 0, '1);
      ask(CMD_RESET_DIR, 0, 1'b0, 0, '1);

      // Extreme settings; the uplink region is above the slot count and gets clamped.
      load_settings(275, 1, 64, 127, 512, 1);
      ask(CMD_ALLOC, 15, 1'b1, 1023, '0);
      ask(CMD_ADMIT, 1, 1'b0, 0, '0);
      ask(CMD_ADMIT, 1, 1'b0, 512, '0);
      ask(CMD_ADMIT, 1, 1'b0, 1, '0);
      ask(CMD_RELEASE, 1, 1'b0, 1023, '0);
      ask(CMD_ADMIT, 1, 1'b1, 1, '0);
      ask(CMD_ADMIT, 1, 1'b1, 1, '0);
      ask(CMD_CLAIM, 2, 1'b0, 0, '0);
      ask(CMD_CLAIM, 2, 1'b0, 64, '0);
      ask(CMD_CLAIM, 2, 1'b0, 1, '0);
      ask(CMD_SHARED, 2, 1'b0, 1023, '0);
      ask(CMD_FREE, 2, 1'b0, 0, 64'hAAAA_AAAA_AAAA_AAAA);
      ask(CMD_FREE, 2, 1'b0, 0, '1);
      ask(CMD_CLAIM, 3, 1'b1, 1, '0);
      ask(CMD_CLAIM, 3, 1'b1, 1, '0);
      ask(CMD_CLAIM, 4, 1'b0, 300, '0);
      ask(CMD_RESET_DIR, 1, 1'b0, 0, '0);
      ask(CMD_RESET_ALL, 9, 1'b1, 1023, '1);

      load_settings(275, 275, 64, 64, 512, 512);
      run_random(100);
      hold_request = 1'b1;
      run_random(300);

      load_settings(1, 1, 0, 0, 0, 0);
      run_random(250);

      repeat (3) begin
         load_settings($urandom_range(1, 275), $urandom_range(1, 275), pick_region(),
                       pick_region(), $urandom_range(0, 512), $urandom_range(0, 512));
         run_random(450);
      end

      drain();
      repeat (20) @(negedge clock);
      $display("Covered %0d requests under %0d register settings, %0d responses checked.",
               sent, settings_loaded + 1, ledger.responses);
      $display("Claims granted %0d, admissions granted %0d, slots freed %0d, %s %0d.",
               ledger.claims_won, ledger.admits_won, ledger.slots_freed,
               "shared saturations", ledger.saturations);
      if (ledger.errors == 0 && ledger.due_responses.size() == 0) begin
         $display("beam_rb_budget_allocator_test: done, clean");
      end else begin
         $display("beam_rb_budget_allocator_test: done, errors");
      end
      $finish;
   end

endmodule
